[rtl/atc_pkg.sv]
// shared types, opcodes and width helpers for the integer alu with trap check
package atc_pkg;

  localparam int unsigned XLEN  = 64;
  localparam int unsigned WBITS = 7;

  // operation codes
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SHL  = 5'd6,
    OP_LSHR = 5'd7,
    OP_ASHR = 5'd8,
    OP_UDIV = 5'd9,
    OP_UREM = 5'd10,
    OP_SDIV = 5'd11,
    OP_SREM = 5'd12,
    OP_ADDT = 5'd13,
    OP_SUBT = 5'd14,
    OP_MULT = 5'd15,
    OP_EQ   = 5'd16,
    OP_NE   = 5'd17,
    OP_SLT  = 5'd18,
    OP_SLE  = 5'd19,
    OP_SGT  = 5'd20,
    OP_SGE  = 5'd21,
    OP_ULT  = 5'd22,
    OP_ULE  = 5'd23,
    OP_UGT  = 5'd24,
    OP_UGE  = 5'd25
  } op_t;

  // width selector codes
  localparam logic [2:0] WSEL_1  = 3'd0;
  localparam logic [2:0] WSEL_8  = 3'd1;
  localparam logic [2:0] WSEL_16 = 3'd2;
  localparam logic [2:0] WSEL_32 = 3'd3;
  localparam logic [2:0] WSEL_64 = 3'd4;

  // divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic [4:0]       op;
    logic [WBITS-1:0] bits;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    logic             pre_ok;
  } dec_t;

  // divider control from back
  typedef struct packed {
    logic start;
    logic take;
  } div_ctl_t;

  // divider status to back
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // sign-extend x from its low bits (bits is 1..64)
  function automatic logic [XLEN-1:0] sext_w(logic [XLEN-1:0] x, logic [WBITS-1:0] bits);
    logic [5:0]             sh;
    logic signed [XLEN-1:0] t;
    sh = 6'(7'd64 - bits);
    t  = $signed(x << sh);
    return $unsigned(t >>> sh);
  endfunction

  // mask of the low bits (bits is 1..64)
  function automatic logic [XLEN-1:0] mask_w(logic [WBITS-1:0] bits);
    logic [XLEN-1:0] m;
    if (bits[6]) begin
      m = '1;
    end else begin
      m = (64'd1 << bits[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

[rtl/atc_front.sv]
// front end: width decode, operand sign extension and trap pre-classification
module atc_front #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [4:0]           in_command,
  input  logic [2:0]           in_width_sel,
  input  logic signed [63:0]   in_operand_a,
  input  logic signed [63:0]   in_operand_b,
  output logic                 q_valid,
  input  logic                 q_ready,
  output atc_pkg::dec_t        q_item
);

  logic                         v_r;
  atc_pkg::dec_t                item_r;
  atc_pkg::dec_t                item_nxt;
  logic [atc_pkg::WBITS-1:0]    bits;
  logic [atc_pkg::XLEN-1:0]     a;
  logic [atc_pkg::XLEN-1:0]     b;
  logic [atc_pkg::XLEN-1:0]     m;
  logic [atc_pkg::XLEN-1:0]     ua;
  logic [atc_pkg::XLEN-1:0]     ub;
  logic [atc_pkg::XLEN-1:0]     smin;
  logic                         ok;
  logic                         take;

  // width decode with clamp
  always_comb begin
    case (in_width_sel)
      atc_pkg::WSEL_1:  bits = 7'd1;
      atc_pkg::WSEL_8:  bits = 7'd8;
      atc_pkg::WSEL_16: bits = 7'd16;
      atc_pkg::WSEL_32: bits = 7'd32;
      default:          bits = 7'd64;
    endcase
    if (32'(bits) > MAX_WIDTH) begin
      bits = 7'(MAX_WIDTH);
    end
  end

  // operand views
  always_comb begin
    a    = atc_pkg::sext_w($unsigned(in_operand_a), bits);
    b    = atc_pkg::sext_w($unsigned(in_operand_b), bits);
    m    = atc_pkg::mask_w(bits);
    ua   = a & m;
    ub   = b & m;
    smin = atc_pkg::sext_w(64'd1 << 6'(bits - 7'd1), bits);
  end

  // classify undefined cases ahead of execution
  always_comb begin
    case (in_command)
      atc_pkg::OP_SHL, atc_pkg::OP_LSHR, atc_pkg::OP_ASHR:
        ok = ub < {57'd0, bits};
      atc_pkg::OP_UDIV, atc_pkg::OP_UREM:
        ok = ub != '0;
      atc_pkg::OP_SDIV, atc_pkg::OP_SREM:
        ok = (b != '0) && !((a == smin) && (b == '1));
      default:
        ok = in_command inside {[atc_pkg::OP_ADD:atc_pkg::OP_UGE]};
    endcase
    item_nxt.op     = in_command;
    item_nxt.bits   = bits;
    item_nxt.a      = a;
    item_nxt.b      = b;
    item_nxt.pre_ok = ok;
  end

  assign take     = in_valid && !in_stall;
  assign in_stall = v_r && !q_ready;
  assign q_valid  = v_r;
  assign q_item   = item_r;

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!v_r || q_ready) begin
      v_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/atc_fifo.sv]
// two-entry queue of decoded items between front and back
module atc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atc_pkg::dec_t  push_item,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output atc_pkg::dec_t  head
);

  atc_pkg::dec_t  ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign ready      = cnt_r != 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = ent_r[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/atc_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module atc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  atc_pkg::div_ctl_t   ctl,
  input  logic [63:0]         dividend,
  input  logic [63:0]         divisor,
  output atc_pkg::div_sts_t   sts,
  output logic [63:0]         quo,
  output logic [63:0]         rem
);

  atc_pkg::div_state_t state_r;
  atc_pkg::div_state_t state_nxt;
  logic [6:0]          cnt_r;
  logic [63:0]         quo_r;
  logic [63:0]         rem_r;
  logic [63:0]         dsr_r;
  logic [64:0]         trial;
  logic [64:0]         diff;
  logic                last;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, dsr_r};
  assign last  = cnt_r == 7'd63;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atc_pkg::DIV_IDLE: if (ctl.start) state_nxt = atc_pkg::DIV_RUN;
      atc_pkg::DIV_RUN:  if (last)      state_nxt = atc_pkg::DIV_DONE;
      atc_pkg::DIV_DONE: if (ctl.take)  state_nxt = atc_pkg::DIV_IDLE;
      default:                          state_nxt = atc_pkg::DIV_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    sts.busy = state_r == atc_pkg::DIV_RUN;
    sts.done = state_r == atc_pkg::DIV_DONE;
  end

  assign quo = quo_r;
  assign rem = rem_r;

  // state and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atc_pkg::DIV_IDLE;
      cnt_r   <= 7'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == atc_pkg::DIV_RUN) begin
        cnt_r <= cnt_r + 7'd1;
      end else begin
        cnt_r <= 7'd0;
      end
    end
  end

  // shift and subtract datapath
  always_ff @(posedge clk) begin
    if (state_r == atc_pkg::DIV_IDLE && ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (state_r == atc_pkg::DIV_RUN) begin
      if (!diff[64]) begin
        rem_r <= diff[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

endmodule

[rtl/atc_back.sv]
// back end: execute stage, multiply pipeline, divider and result register
module atc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  atc_pkg::dec_t        head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [63:0]   out_value,
  output logic                 out_valid_res
);

  // execute stage slot
  typedef struct packed {
    logic        is_mul;
    logic        trap;
    logic        ok;
    logic [6:0]  bits;
    logic        na;
    logic        nb;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] val;
    logic [63:0] p_ll;
    logic [63:0] p_lh;
    logic [63:0] p_hl;
    logic [63:0] p_hh;
  } e1_t;

  // product sum slot
  typedef struct packed {
    logic        is_mul;
    logic        trap;
    logic        ok;
    logic [6:0]  bits;
    logic        na;
    logic        nb;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] val;
    logic [63:0] hi;
  } e2_t;

  logic              e1_v_r;
  logic              e2_v_r;
  logic              o_v_r;
  e1_t               e1_r;
  e1_t               e1_nxt;
  e2_t               e2_r;
  e2_t               e2_nxt;
  logic [63:0]       o_val_r;
  logic [63:0]       o_val_nxt;
  logic              o_ok_r;
  logic              o_ok_nxt;
  logic              adv1;
  logic              adv2;
  logic              adv3;
  logic              is_div;
  atc_pkg::div_ctl_t dctl;
  atc_pkg::div_sts_t dsts;
  logic [63:0]       dq;
  logic [63:0]       dr;
  logic [63:0]       m;
  logic [63:0]       ua;
  logic [63:0]       ub;
  logic [63:0]       ma;
  logic [63:0]       mb;
  logic              na;
  logic              nb;
  logic [5:0]        sh;
  logic [64:0]       s65;
  logic [63:0]       r;
  logic              fit;
  logic [127:0]      prod;
  logic [63:0]       hi_c;
  logic              mfit;

  assign adv3 = !o_v_r || !out_stall;
  assign adv2 = !e2_v_r || adv3;
  assign adv1 = !e1_v_r || adv2;

  // divide steering
  always_comb begin
    case (head.op)
      atc_pkg::OP_UDIV, atc_pkg::OP_UREM, atc_pkg::OP_SDIV, atc_pkg::OP_SREM:
        is_div = head_valid && head.pre_ok;
      default:
        is_div = 1'b0;
    endcase
    dctl.start = is_div && !dsts.busy && !dsts.done;
    dctl.take  = is_div && dsts.done && adv1;
    pop        = head_valid && adv1 && (!is_div || dsts.done);
  end

  // operand views for execution
  always_comb begin
    m  = atc_pkg::mask_w(head.bits);
    ua = head.a & m;
    ub = head.b & m;
    na = head.a[63];
    nb = head.b[63];
    ma = na ? 64'd0 - head.a : head.a;
    mb = nb ? 64'd0 - head.b : head.b;
    sh = ub[5:0];
  end

  atc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend ((head.op == atc_pkg::OP_SDIV || head.op == atc_pkg::OP_SREM) ? ma : ua),
    .divisor  ((head.op == atc_pkg::OP_SDIV || head.op == atc_pkg::OP_SREM) ? mb : ub),
    .sts      (dsts),
    .quo      (dq),
    .rem      (dr)
  );

  // operations computed in the execute stage and divide result pickup
  always_comb begin
    r   = '0;
    fit = 1'b1;
    s65 = '0;
    case (head.op)
      atc_pkg::OP_ADD:  r = head.a + head.b;
      atc_pkg::OP_SUB:  r = head.a - head.b;
      atc_pkg::OP_AND:  r = head.a & head.b;
      atc_pkg::OP_OR:   r = head.a | head.b;
      atc_pkg::OP_XOR:  r = head.a ^ head.b;
      atc_pkg::OP_SHL:  r = ua << sh;
      atc_pkg::OP_LSHR: r = ua >> sh;
      atc_pkg::OP_ASHR: r = $unsigned($signed(head.a) >>> sh);
      atc_pkg::OP_UDIV: r = dq;
      atc_pkg::OP_UREM: r = dr;
      atc_pkg::OP_SDIV: r = (na != nb) ? 64'd0 - dq : dq;
      atc_pkg::OP_SREM: r = na ? 64'd0 - dr : dr;
      atc_pkg::OP_ADDT, atc_pkg::OP_SUBT: begin
        if (head.op == atc_pkg::OP_ADDT) begin
          s65 = {head.a[63], head.a} + {head.b[63], head.b};
        end else begin
          s65 = {head.a[63], head.a} - {head.b[63], head.b};
        end
        r   = s65[63:0];
        fit = (s65[64] == s65[63]) && (atc_pkg::sext_w(s65[63:0], head.bits) == s65[63:0]);
      end
      atc_pkg::OP_EQ:  r = 64'(head.a == head.b);
      atc_pkg::OP_NE:  r = 64'(head.a != head.b);
      atc_pkg::OP_SLT: r = 64'($signed(head.a) <  $signed(head.b));
      atc_pkg::OP_SLE: r = 64'($signed(head.a) <= $signed(head.b));
      atc_pkg::OP_SGT: r = 64'($signed(head.a) >  $signed(head.b));
      atc_pkg::OP_SGE: r = 64'($signed(head.a) >= $signed(head.b));
      atc_pkg::OP_ULT: r = 64'(ua <  ub);
      atc_pkg::OP_ULE: r = 64'(ua <= ub);
      atc_pkg::OP_UGT: r = 64'(ua >  ub);
      atc_pkg::OP_UGE: r = 64'(ua >= ub);
      default:         r = '0;
    endcase

    e1_nxt.is_mul = head.op == atc_pkg::OP_MUL || head.op == atc_pkg::OP_MULT;
    e1_nxt.trap   = head.op == atc_pkg::OP_MULT;
    e1_nxt.ok     = head.pre_ok && fit;
    e1_nxt.bits   = head.bits;
    e1_nxt.na     = na;
    e1_nxt.nb     = nb;
    e1_nxt.a      = head.a;
    e1_nxt.b      = head.b;
    if (!(head.pre_ok && fit)) begin
      e1_nxt.val = '0;
    end else if (head.op < atc_pkg::OP_EQ) begin
      e1_nxt.val = atc_pkg::sext_w(r, head.bits);
    end else begin
      e1_nxt.val = r;
    end
    // 32x32 partial products
    e1_nxt.p_ll = head.a[31:0]  * head.b[31:0];
    e1_nxt.p_lh = head.a[31:0]  * head.b[63:32];
    e1_nxt.p_hl = head.a[63:32] * head.b[31:0];
    e1_nxt.p_hh = head.a[63:32] * head.b[63:32];
  end

  // partial product sum into unsigned 128-bit product
  always_comb begin
    prod = {e1_r.p_hh, e1_r.p_ll}
         + {32'd0, e1_r.p_lh, 32'd0}
         + {32'd0, e1_r.p_hl, 32'd0};
    e2_nxt.is_mul = e1_r.is_mul;
    e2_nxt.trap   = e1_r.trap;
    e2_nxt.ok     = e1_r.ok;
    e2_nxt.bits   = e1_r.bits;
    e2_nxt.na     = e1_r.na;
    e2_nxt.nb     = e1_r.nb;
    e2_nxt.a      = e1_r.a;
    e2_nxt.b      = e1_r.b;
    e2_nxt.val    = e1_r.is_mul ? prod[63:0] : e1_r.val;
    e2_nxt.hi     = prod[127:64];
  end

  // signed correction, overflow check and final sign extension
  always_comb begin
    hi_c = e2_r.hi - (e2_r.na ? e2_r.b : 64'd0) - (e2_r.nb ? e2_r.a : 64'd0);
    mfit = (hi_c == {64{e2_r.val[63]}})
        && (atc_pkg::sext_w(e2_r.val, e2_r.bits) == e2_r.val);
    if (e2_r.is_mul) begin
      o_ok_nxt  = !e2_r.trap || mfit;
      o_val_nxt = o_ok_nxt ? atc_pkg::sext_w(e2_r.val, e2_r.bits) : 64'd0;
    end else begin
      o_ok_nxt  = e2_r.ok;
      o_val_nxt = e2_r.val;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (adv1) e1_v_r <= pop;
      if (adv2) e2_v_r <= e1_v_r;
      if (adv3) o_v_r  <= e2_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1 && pop) e1_r <= e1_nxt;
    if (adv2 && e1_v_r) e2_r <= e2_nxt;
    if (adv3 && e2_v_r) begin
      o_val_r <= o_val_nxt;
      o_ok_r  <= o_ok_nxt;
    end
  end

  assign out_valid     = o_v_r;
  assign out_value     = $signed(o_val_r);
  assign out_valid_res = o_ok_r;

endmodule

[rtl/integer_alu_trap_check.sv]
// top level of the integer alu with trap check
// One operation per cycle is accepted while out_stall does not hold the pipeline,
// for every command except the four divides: a divide that does not trap holds
// the head of the queue through a start step, the run of the bit-serial divider,
// which produces one quotient bit per cycle, and a handoff step, and items behind
// it wait in the two-entry queue and then the input register. A divide that traps
// passes at full rate. A result passes five registers (input register, queue,
// execute, product sum, result register) before it is presented.
// Multiplies use four 32x32 partial products. MAX_WIDTH clamps the selected
// operand width.
module integer_alu_trap_check #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [4:0]          in_command,
  input  logic [2:0]          in_width_sel,
  input  logic signed [63:0]  in_operand_a,
  input  logic signed [63:0]  in_operand_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  out_value,
  output logic                out_valid_res
);

  logic          q_valid;
  logic          q_ready;
  atc_pkg::dec_t q_item;
  logic          head_valid;
  atc_pkg::dec_t head;
  logic          pop;

  // front end
  atc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_width_sel (in_width_sel),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  // decoupling queue
  atc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_valid),
    .push_item  (q_item),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end
  atc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_valid_res (out_valid_res)
  );

endmodule

[rtl/atc_checker.sv]
// port-level checks for the integer alu with trap check, bound to the top level
module atc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] out_value,
  input logic               out_valid_res
);

  // a trapped result always carries zero
  a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_value == 64'sd0)
    else $error("trapped result with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_valid_res))
    else $error("stalled result changed");

  // nothing is delivered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integer_alu_trap_check atc_checker u_atc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_valid_res (out_valid_res)
);
